>>> hw/rtl/sec_pkg.sv
// Shared types and widths for the sphere collision core.
// Holds the input, result and front-to-back word layouts; no dependencies.
package sec_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned VelAbsW = 65;                  // |(v2 - v1) . o|
  localparam int unsigned NumW   = VelAbsW + WordW;      // |D| * |o_k|
  localparam int unsigned QsumW  = 64;                   // o . o
  localparam int unsigned MsumW  = WordW + 1;            // m1 + m2
  localparam int unsigned Div1QW = 33;                   // floor(|g|) < 2^33
  localparam int unsigned GmagW  = Div1QW + 1;
  localparam int unsigned Prod2W = GmagW + WordW + 1;    // |g| * 2m
  localparam int unsigned Div2QW = 34;                   // floor(|a|) < 2^34
  localparam int unsigned AdjW   = Div2QW + 1;

  typedef struct packed {
    logic signed [WordW-1:0] offset_x;
    logic signed [WordW-1:0] offset_y;
    logic signed [WordW-1:0] offset_z;
    logic signed [WordW-1:0] first_vel_x;
    logic signed [WordW-1:0] first_vel_y;
    logic signed [WordW-1:0] first_vel_z;
    logic signed [WordW-1:0] second_vel_x;
    logic signed [WordW-1:0] second_vel_y;
    logic signed [WordW-1:0] second_vel_z;
    logic [WordW-1:0]        first_mass;
    logic [WordW-1:0]        second_mass;
  } in_word_t;

  typedef struct packed {
    logic signed [WordW-1:0] new_first_x;
    logic signed [WordW-1:0] new_first_y;
    logic signed [WordW-1:0] new_first_z;
    logic signed [WordW-1:0] new_second_x;
    logic signed [WordW-1:0] new_second_y;
    logic signed [WordW-1:0] new_second_z;
    logic                    coincident_flag;
  } out_word_t;

  typedef struct packed {
    logic [2:0][NumW-1:0]  num;
    logic [QsumW-1:0]      qsum;
    logic [2:0][WordW-1:0] v1;
    logic [2:0][WordW-1:0] v2;
    logic [WordW-1:0]      m1;
    logic [WordW-1:0]      m2;
    logic [2:0]            gneg;
    logic                  coinc;
    logic                  pass;
  } fb_word_t;

endpackage

>>> hw/rtl/sec_queue.sv
// Small register queue between the front and back parts of the collision core.
// Generic over word width and depth; no package dependency.
module sec_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

>>> hw/rtl/sec_div.sv
// Pipelined restoring divider with round-half-up on the remainder.
// One quotient bit per stage plus a rounding stage; no package dependency.
module sec_div #(
  parameter int unsigned NW = 97,
  parameter int unsigned DW = 64,
  parameter int unsigned QW = 33
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW:0]   quo_o
);
  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW:0]   quo_q;
  logic [DW:0]   rem2;

  // low_q shifts numerator bits out at the top and quotient bits in at the bottom
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0] rem_in, den_in;
    logic [QW-1:0] low_in;
    logic [DW:0]   shifted, diff;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in = DW'(num_i[NW-1:QW]);
      assign den_in = den_i;
      assign low_in = num_i[QW-1:0];
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign low_in = low_q[s-1];
    end

    assign shifted = {rem_in, low_in[QW-1]};
    assign diff    = shifted - {1'b0, den_in};
    assign take    = (shifted >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? diff[DW-1:0] : shifted[DW-1:0];
        den_q[s] <= den_in;
        low_q[s] <= {low_in[QW-2:0], take};
      end
    end
  end

  assign rem2 = {rem_q[QW-1], 1'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= {1'b0, low_q[QW-1]} + (QW+1)'(rem2 >= {1'b0, den_q[QW-1]});
    end
  end

  assign quo_o = quo_q;

endmodule

>>> hw/rtl/sec_front.sv
// Front part: takes words, forms D = (v2 - v1) . o, Q = o . o and |D| * |o_k|.
// Depends on sec_pkg.
module sec_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  sec_pkg::in_word_t in_word_i,
  output logic              fb_valid_o,
  input  logic              fb_full_i,
  output sec_pkg::fb_word_t fb_word_o
);
  import sec_pkg::*;

  localparam int unsigned NStg = 6;

  logic [NStg-1:0] v_q;
  logic            en;

  in_word_t s1_q, s2_q, s3_q, s4_q, s5_q, s6_q;

  logic signed [WordW:0]     dv [3];
  logic signed [WordW-1:0]   o1 [3];
  logic [WordW-1:0]          oabs1 [3];
  logic signed [WordW-1:0]   v1_1 [3];
  logic signed [WordW-1:0]   v2_1 [3];

  logic signed [64:0]        prod2_q [3];
  logic [QsumW-1:0]          sq2_q [3];
  logic [WordW-1:0]          oabs2_q [3], oabs3_q [3], oabs4_q [3];
  logic [2:0]                oneg2_q, oneg3_q;

  logic signed [66:0]        dsum3_q;
  logic [QsumW-1:0]          qsum3_q, qsum4_q, qsum5_q, qsum6_q;
  logic                      mzero3_q;

  logic [VelAbsW-1:0]        dabs4_q;
  logic [2:0]                gneg4_q, gneg5_q, gneg6_q;
  logic                      coinc4_q, coinc5_q, coinc6_q;
  logic                      pass4_q, pass5_q, pass6_q;

  logic [63:0]               plo5_q [3];
  logic [64:0]               phi5_q [3];
  logic [NumW-1:0]           num6_q [3];

  assign en         = !v_q[NStg-1] || !fb_full_i;
  assign full_o     = !en;
  assign fb_valid_o = v_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NStg-2:0], push_i};
    end
  end

  always_comb begin
    o1[0]   = s1_q.offset_x;
    o1[1]   = s1_q.offset_y;
    o1[2]   = s1_q.offset_z;
    v1_1[0] = s1_q.first_vel_x;
    v1_1[1] = s1_q.first_vel_y;
    v1_1[2] = s1_q.first_vel_z;
    v2_1[0] = s1_q.second_vel_x;
    v2_1[1] = s1_q.second_vel_y;
    v2_1[2] = s1_q.second_vel_z;
    for (int k = 0; k < 3; k++) begin
      dv[k]    = $signed({v2_1[k][WordW-1], v2_1[k]}) - $signed({v1_1[k][WordW-1], v1_1[k]});
      oabs1[k] = o1[k][WordW-1] ? (~o1[k] + 1'b1) : o1[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= in_word_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
      s4_q <= s3_q;
      s5_q <= s4_q;
      s6_q <= s5_q;

      // products and squares
      for (int k = 0; k < 3; k++) begin
        prod2_q[k] <= dv[k] * o1[k];
        sq2_q[k]   <= oabs1[k] * oabs1[k];
        oabs2_q[k] <= oabs1[k];
        oneg2_q[k] <= o1[k][WordW-1];
      end

      // sums
      dsum3_q  <= 67'(prod2_q[0]) + 67'(prod2_q[1]) + 67'(prod2_q[2]);
      qsum3_q  <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      mzero3_q <= (s2_q.first_mass == '0) && (s2_q.second_mass == '0);
      oabs3_q  <= oabs2_q;
      oneg3_q  <= oneg2_q;

      // magnitude of D and flags
      dabs4_q  <= VelAbsW'(dsum3_q[66] ? -dsum3_q : dsum3_q);
      gneg4_q  <= {3{dsum3_q[66]}} ^ oneg3_q;
      coinc4_q <= (qsum3_q == '0);
      pass4_q  <= (qsum3_q == '0) || mzero3_q;
      qsum4_q  <= qsum3_q;
      oabs4_q  <= oabs3_q;

      // split |D| into two halves for the multipliers
      for (int k = 0; k < 3; k++) begin
        plo5_q[k] <= dabs4_q[31:0] * oabs4_q[k];
        phi5_q[k] <= dabs4_q[VelAbsW-1:32] * oabs4_q[k];
      end
      gneg5_q  <= gneg4_q;
      coinc5_q <= coinc4_q;
      pass5_q  <= pass4_q;
      qsum5_q  <= qsum4_q;

      for (int k = 0; k < 3; k++) begin
        num6_q[k] <= {phi5_q[k], 32'b0} + NumW'(plo5_q[k]);
      end
      gneg6_q  <= gneg5_q;
      coinc6_q <= coinc5_q;
      pass6_q  <= pass5_q;
      qsum6_q  <= qsum5_q;
    end
  end

  always_comb begin
    fb_word_o.num[0] = num6_q[0];
    fb_word_o.num[1] = num6_q[1];
    fb_word_o.num[2] = num6_q[2];
    fb_word_o.qsum   = qsum6_q;
    fb_word_o.v1[0]  = s6_q.first_vel_x;
    fb_word_o.v1[1]  = s6_q.first_vel_y;
    fb_word_o.v1[2]  = s6_q.first_vel_z;
    fb_word_o.v2[0]  = s6_q.second_vel_x;
    fb_word_o.v2[1]  = s6_q.second_vel_y;
    fb_word_o.v2[2]  = s6_q.second_vel_z;
    fb_word_o.m1     = s6_q.first_mass;
    fb_word_o.m2     = s6_q.second_mass;
    fb_word_o.gneg   = gneg6_q;
    fb_word_o.coinc  = coinc6_q;
    fb_word_o.pass   = pass6_q;
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NStg-1] && fb_full_i) |=> v_q[NStg-1])
    else $error("front dropped a word while the queue was full");

endmodule

>>> hw/rtl/sec_back.sv
// Back part: normal component per axis, mass split, sign, add and saturate.
// Depends on sec_pkg and sec_div.
module sec_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  sec_pkg::fb_word_t  in_word_i,
  output logic               in_take_o,
  output logic               empty_o,
  input  logic               pop_i,
  output sec_pkg::out_word_t out_word_o
);
  import sec_pkg::*;

  localparam int unsigned L1  = Div1QW + 1;
  localparam int unsigned L2  = Div2QW + 1;
  localparam int unsigned NSt = L1 + L2 + 2;

  typedef struct packed {
    logic [2:0][WordW-1:0] v1;
    logic [2:0][WordW-1:0] v2;
    logic [WordW-1:0]      m1;
    logic [WordW-1:0]      m2;
    logic [2:0]            gneg;
    logic                  coinc;
    logic                  pass;
  } sb_t;

  logic [NSt-1:0]   v_q;
  sb_t              sb_q [NSt-1];
  logic             en;
  logic [GmagW-1:0] gmag [3];
  logic [Prod2W-1:0] p1_q [3], p2_q [3];
  logic [MsumW-1:0] msum_q;
  logic [AdjW-1:0]  a1 [3], a2 [3];
  logic [WordW-1:0] nf [3], ns [3];
  out_word_t        out_q, out_d;
  sb_t              sb_last;

  function automatic logic [WordW-1:0] sat32(input logic signed [36:0] x);
    logic [WordW-1:0] r;
    if (x[36:31] == 6'b000000 || x[36:31] == 6'b111111) begin
      r = x[WordW-1:0];
    end else if (x[36]) begin
      r = {1'b1, {(WordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(WordW-1){1'b1}}};
    end
    return r;
  endfunction

  assign en        = !v_q[NSt-1] || pop_i;
  assign in_take_o = en && in_valid_i;
  assign empty_o   = !v_q[NSt-1];
  assign out_word_o = out_q;
  assign sb_last   = sb_q[NSt-2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSt-2:0], in_valid_i};
    end
  end

  // sideband travels alongside the dividers
  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0].v1    <= in_word_i.v1;
      sb_q[0].v2    <= in_word_i.v2;
      sb_q[0].m1    <= in_word_i.m1;
      sb_q[0].m2    <= in_word_i.m2;
      sb_q[0].gneg  <= in_word_i.gneg;
      sb_q[0].coinc <= in_word_i.coinc;
      sb_q[0].pass  <= in_word_i.pass;
      for (int i = 1; i < NSt - 1; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    sec_div #(.NW(NumW), .DW(QsumW), .QW(Div1QW)) u_div_norm (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (in_word_i.num[k]),
      .den_i (in_word_i.qsum),
      .quo_o (gmag[k])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        p1_q[k] <= gmag[k] * {sb_q[L1-1].m2, 1'b0};
        p2_q[k] <= gmag[k] * {sb_q[L1-1].m1, 1'b0};
      end
    end

    sec_div #(.NW(Prod2W), .DW(MsumW), .QW(Div2QW)) u_div_first (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (p1_q[k]),
      .den_i (msum_q),
      .quo_o (a1[k])
    );

    sec_div #(.NW(Prod2W), .DW(MsumW), .QW(Div2QW)) u_div_second (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (p2_q[k]),
      .den_i (msum_q),
      .quo_o (a2[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      msum_q <= {1'b0, sb_q[L1-1].m1} + {1'b0, sb_q[L1-1].m2};
      out_q  <= out_d;
    end
  end

  always_comb begin
    logic signed [36:0] d1, d2, s1, s2;
    for (int k = 0; k < 3; k++) begin
      d1 = $signed({2'b00, a1[k]});
      d2 = $signed({2'b00, a2[k]});
      // first sphere gains along the normal, second loses
      if (sb_last.gneg[k]) begin
        d1 = -d1;
      end else begin
        d2 = -d2;
      end
      s1 = $signed({{5{sb_last.v1[k][WordW-1]}}, sb_last.v1[k]}) + d1;
      s2 = $signed({{5{sb_last.v2[k][WordW-1]}}, sb_last.v2[k]}) + d2;
      nf[k] = sb_last.pass ? sb_last.v1[k] : sat32(s1);
      ns[k] = sb_last.pass ? sb_last.v2[k] : sat32(s2);
    end
    out_d.new_first_x     = nf[0];
    out_d.new_first_y     = nf[1];
    out_d.new_first_z     = nf[2];
    out_d.new_second_x    = ns[0];
    out_d.new_second_y    = ns[1];
    out_d.new_second_z    = ns[2];
    out_d.coincident_flag = sb_last.coinc;
  end

  a_coinc_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NSt-2] && sb_last.coinc) |-> sb_last.pass)
    else $error("coincident word not marked for pass-through");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NSt-1] && !pop_i) |=> v_q[NSt-1])
    else $error("back dropped a waiting word");

endmodule

>>> hw/rtl/sphere_elastic_collision_core.sv
// Top level of the elastic collision core for two spheres.
// Depends on sec_pkg, sec_front, sec_queue and sec_back.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------
//   input    | push / full         | in_word_i  (sec_pkg::in_word_t)
//   result   | empty / pop         | out_word_o (sec_pkg::out_word_t)
//
// One word per cycle sustained while results are popped; a word passes
// the front stages, the queue, then the two chains of bit-per-stage dividers.
// Reset clears all valid bits and the queue; no clearing pass is needed.
// A stalled result holds the back part, the queue then fills and full rises.
module sphere_elastic_collision_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  sec_pkg::in_word_t  in_word_i,
  output logic               empty,
  input  logic               pop,
  output sec_pkg::out_word_t out_word_o
);
  import sec_pkg::*;

  localparam int unsigned FbW = $bits(fb_word_t);

  fb_word_t       fb_word, q_word;
  logic           fb_valid, q_full, q_empty, q_take;
  logic [FbW-1:0] q_rdata;

  sec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_word_i  (in_word_i),
    .fb_valid_o (fb_valid),
    .fb_full_i  (q_full),
    .fb_word_o  (fb_word)
  );

  sec_queue #(.WIDTH(FbW), .DEPTH(2)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fb_valid),
    .data_i  (FbW'(fb_word)),
    .full_o  (q_full),
    .pop_i   (q_take),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  assign q_word = fb_word_t'(q_rdata);

  sec_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!q_empty),
    .in_word_i  (q_word),
    .in_take_o  (q_take),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_word_o (out_word_o)
  );

endmodule

>>> tb/sv/tb_top.sv
// Testbench for sphere_elastic_collision_core: directed rows, then random pairs.
// Predicts each new velocity pair in-line and checks the results in order.
// Depends on sec_pkg and the core RTL only.
module tb_top;
  import sec_pkg::*;

  localparam logic [63:0] MagCap  = 64'd1 << 40;
  localparam int          NumRand = 700;
  localparam logic [31:0] One     = 32'h0001_0000;
  localparam logic [31:0] MaxPos  = 32'h7fff_ffff;
  localparam logic [31:0] MaxNeg  = 32'h8000_0000;

  typedef struct {
    in_word_t  stim;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_word_t  in_word_i;
  logic      empty;
  logic      pop;
  out_word_t out_word_o;

  out_word_t pending_velocities[$];
  dir_row_t  dir_rows[$];
  int        n_mismatch;
  bit        hold_results;
  int        n_accepted;

  sphere_elastic_collision_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [63:0] mag_of(input logic signed [63:0] a);
    return (a < 0) ? 64'(-a) : 64'(a);
  endfunction

  // Round half away from zero, capped at 2^40.
  function automatic logic [63:0] div_near(input logic [127:0] n, input logic [63:0] dv);
    logic [127:0] qt;
    logic [127:0] rm;
    logic [63:0]  qq;
    qt = n / {64'd0, dv};
    rm = n % {64'd0, dv};
    if (qt[127:64] != 0) return MagCap;
    qq = qt[63:0];
    if (rm[63:0] >= dv - rm[63:0]) qq = qq + 1;
    if (qq > MagCap) qq = MagCap;
    return qq;
  endfunction

  function automatic logic [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return MaxPos;
    if (v < -64'sd2147483648) return MaxNeg;
    return v[31:0];
  endfunction

  function automatic out_word_t collide_pair(input in_word_t w);
    logic signed [63:0]  o[3];
    logic signed [63:0]  v1[3];
    logic signed [63:0]  v2[3];
    logic signed [127:0] dot;
    logic signed [127:0] term;
    logic [127:0]        dmag;
    logic [63:0]         qsum;
    logic [63:0]         m1;
    logic [63:0]         m2;
    logic [63:0]         msum;
    logic [63:0]         gmag;
    logic [63:0]         a1;
    logic [63:0]         a2;
    logic signed [63:0]  d1;
    logic signed [63:0]  d2;
    logic [31:0]         r1[3];
    logic [31:0]         r2[3];
    bit                  dneg;
    bit                  gneg;
    out_word_t           res;
    o[0] = w.offset_x;  o[1] = w.offset_y;  o[2] = w.offset_z;
    v1[0] = w.first_vel_x;  v1[1] = w.first_vel_y;  v1[2] = w.first_vel_z;
    v2[0] = w.second_vel_x; v2[1] = w.second_vel_y; v2[2] = w.second_vel_z;
    m1 = {32'd0, w.first_mass};
    m2 = {32'd0, w.second_mass};
    msum = m1 + m2;
    qsum = 0;
    dot = 0;
    for (int k = 0; k < 3; k++) begin
      qsum = qsum + mag_of(o[k]) * mag_of(o[k]);
      term = v2[k] - v1[k];
      term = term * o[k];
      dot = dot + term;
    end
    for (int k = 0; k < 3; k++) begin
      r1[k] = v1[k][31:0];
      r2[k] = v2[k][31:0];
    end
    if (qsum != 0 && msum != 0) begin
      dneg = dot < 0;
      dmag = dneg ? 128'(-dot) : 128'(dot);
      for (int k = 0; k < 3; k++) begin
        gneg = dneg != (o[k] < 0);
        gmag = div_near(dmag * {64'd0, mag_of(o[k])}, qsum);
        a1 = div_near({64'd0, gmag} * {64'd0, 2 * m2}, msum);
        a2 = div_near({64'd0, gmag} * {64'd0, 2 * m1}, msum);
        d1 = gneg ? -$signed(a1) : $signed(a1);
        d2 = gneg ? $signed(a2) : -$signed(a2);
        r1[k] = clip32(v1[k] + d1);
        r2[k] = clip32(v2[k] + d2);
      end
    end
    res.new_first_x = r1[0];  res.new_first_y = r1[1];  res.new_first_z = r1[2];
    res.new_second_x = r2[0]; res.new_second_y = r2[1]; res.new_second_z = r2[2];
    res.coincident_flag = (qsum == 0);
    return res;
  endfunction

  function automatic in_word_t mk_word(input logic [31:0] ox, oy, oz, ax, ay, az,
                                       bx, by, bz, m1, m2);
    return in_word_t'{ox, oy, oz, ax, ay, az, bx, by, bz, m1, m2};
  endfunction

  task automatic add_row(input in_word_t w, input bit typed, input out_word_t want);
    dir_row_t r;
    r.stim = w;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  function automatic logic [31:0] rand_field(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
      default: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 9))
      0: return 32'd1;
      1: return 32'hffff_ffff;
      2: return $urandom();
      default: return $urandom_range(32'h0000_4000, 32'h0010_0000);
    endcase
  endfunction

  function automatic in_word_t rand_word();
    int        mode;
    in_word_t  w;
    mode = $urandom_range(0, 3);
    w = mk_word(rand_field(mode), rand_field(mode), rand_field(mode),
                rand_field(mode), rand_field(mode), rand_field(mode),
                rand_field(mode), rand_field(mode), rand_field(mode),
                rand_mass(), rand_mass());
    // Occasionally flatten the offset onto an axis or to zero.
    case ($urandom_range(0, 19))
      0: begin w.offset_x = 0; w.offset_y = 0; w.offset_z = 0; end
      1: begin w.offset_y = 0; w.offset_z = 0; end
      2: begin w.offset_x = 0; w.offset_z = 0; end
      default: ;
    endcase
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic report(input string field, input logic [31:0] want, got);
    if (n_mismatch < 10)
      $display("mismatch %s: expected %h, got %h", field, want, got);
    n_mismatch++;
  endtask

  task automatic check_word(input out_word_t want, input out_word_t got);
    if (want.new_first_x !== got.new_first_x)
      report("new_first_x", want.new_first_x, got.new_first_x);
    if (want.new_first_y !== got.new_first_y)
      report("new_first_y", want.new_first_y, got.new_first_y);
    if (want.new_first_z !== got.new_first_z)
      report("new_first_z", want.new_first_z, got.new_first_z);
    if (want.new_second_x !== got.new_second_x)
      report("new_second_x", want.new_second_x, got.new_second_x);
    if (want.new_second_y !== got.new_second_y)
      report("new_second_y", want.new_second_y, got.new_second_y);
    if (want.new_second_z !== got.new_second_z)
      report("new_second_z", want.new_second_z, got.new_second_z);
    if (want.coincident_flag !== got.coincident_flag)
      report("coincident_flag", 32'(want.coincident_flag), 32'(got.coincident_flag));
  endtask

  // Sender: directed rows, then random pairs.
  initial begin
    in_word_t  w;
    out_word_t want;
    bit        typed;
    int        gap;
    int        total;
    bit        burst;
    rst_ni = 1'b0;
    push = 1'b0;
    in_word_i = '0;
    n_mismatch = 0;
    n_accepted = 0;

    add_row(mk_word(0, 0, 0, MaxPos, MaxNeg, One, MaxNeg, MaxPos, 32'hffff_0000, One, One),
            1, out_word_t'{MaxPos, MaxNeg, One, MaxNeg, MaxPos, 32'hffff_0000, 1'b1});
    add_row(mk_word(0, 0, 0, 1, 2, 3, 4, 5, 6, 32'hffff_ffff, 1),
            1, out_word_t'{32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 1'b1});
    // Both masses zero: pass through without the flag.
    add_row(mk_word(One, 0, 0, One, 2 * One, 0, -One, 0, One, 0, 0),
            1, out_word_t'{One, 2 * One, 32'd0, -One, 32'd0, One, 1'b0});
    // Head-on, equal masses: velocities swap along x.
    add_row(mk_word(One, 0, 0, -One, 0, 0, One, 0, 0, One, One), 0, '0);
    add_row(mk_word(0, -One, 0, 0, 3 * One, 0, 0, -One, 0, One, 4 * One), 0, '0);
    add_row(mk_word(0, 0, 1, 0, 0, 5, 0, 0, -7, 3, 5), 0, '0);
    // One mass zero.
    add_row(mk_word(One, One, 0, One, 0, 0, 0, One, 0, 0, One), 0, '0);
    add_row(mk_word(One, One, One, One, 0, -One, 0, One, 0, One, 0), 0, '0);
    // Extremes and saturation.
    add_row(mk_word(MaxPos, MaxPos, MaxPos, MaxNeg, MaxNeg, MaxNeg, MaxPos, MaxPos, MaxPos,
                    32'hffff_ffff, 32'hffff_ffff), 0, '0);
    add_row(mk_word(MaxNeg, MaxNeg, MaxNeg, MaxPos, MaxPos, MaxPos, MaxNeg, MaxNeg, MaxNeg,
                    1, 32'hffff_ffff), 0, '0);
    add_row(mk_word(MaxNeg, 0, 0, MaxPos, 0, 0, MaxNeg, 0, 0, 32'hffff_ffff, 1), 0, '0);
    add_row(mk_word(1, MaxNeg, 1, MaxNeg, 1, MaxPos, MaxPos, -1, MaxNeg, 1, 1), 0, '0);
    add_row(mk_word(-1, -1, -1, -1, -1, -1, 1, 1, 1, 32'hffff_ffff, 32'hffff_ffff), 0, '0);
    add_row(mk_word(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h3333_3333,
                    32'hcccc_cccc, 32'h1234_5678, 32'h8765_4321, 32'hdead_beef,
                    32'haaaa_aaaa, 32'h5555_5555), 0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    total = dir_rows.size() + NumRand;
    burst = 0;
    for (int i = 0; i < total; i++) begin
      if (i < dir_rows.size()) begin
        w = dir_rows[i].stim;
        typed = dir_rows[i].typed;
        want = dir_rows[i].want;
      end else begin
        w = rand_word();
        typed = 0;
      end
      if (!typed) want = collide_pair(w);
      if (i % 100 == 0) burst = $urandom_range(0, 2) == 0;
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      push <= 1'b1;
      in_word_i <= w;
      do @(posedge clk_i); while (full);
      pending_velocities.push_back(want);
      n_accepted++;
    end
    push <= 1'b0;

    wait (pending_velocities.size() == 0);
    repeat (200) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: random stalls, checks each word taken.
  initial begin
    int stall;
    pop = 1'b0;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_velocities.size() == 0) begin
          if (n_mismatch < 10) $display("unexpected word %h", out_word_o);
          n_mismatch++;
        end else begin
          check_word(pending_velocities.pop_front(), out_word_o);
        end
      end
      if (stall == 0) stall = pick_gap();
      if (hold_results || stall > 0) begin
        pop <= 1'b0;
        if (stall > 0) stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Hold results off for a long stretch so the core fills and raises full.
  initial begin
    hold_results = 0;
    wait (n_accepted >= 200);
    @(posedge clk_i);
    hold_results = 1;
    repeat (400) @(posedge clk_i);
    hold_results = 0;
  end

  initial begin
    #(20 * 400000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sec_pkg.sv
hw/rtl/sec_queue.sv
hw/rtl/sec_div.sv
hw/rtl/sec_front.sv
hw/rtl/sec_back.sv
hw/rtl/sphere_elastic_collision_core.sv
tb/sv/tb_top.sv
